>>> sv/pas_pkg.sv
package pas_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int WORD_W = 2 * COORD_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [ACC_W-1:0]      acc_t;

    // op control for the shared multiply-accumulate unit
    typedef struct packed {
        logic en;   // issue a product
        logic clr;  // start a new sum with this product
        logic neg;  // subtract this product
    } pas_mac_ctl_t;

    function automatic diff_t coord_diff(input coord_t a, input coord_t b);
        coord_diff = DIFF_W'(a) - DIFF_W'(b);
    endfunction

endpackage

>>> sv/pas_mac.sv
module pas_mac
    import pas_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  pas_mac_ctl_t ctl,
    input  diff_t        op_a,
    input  diff_t        op_b,
    output acc_t         acc
);

    logic signed [PROD_W-1:0] prod_reg;
    pas_mac_ctl_t             ctl_reg;
    acc_t                     acc_reg;
    acc_t                     acc_next;
    acc_t                     term;

    // stage 1: product; stage 2: accumulate
    always_comb begin
        term     = ctl_reg.neg ? -ACC_W'(prod_reg) : ACC_W'(prod_reg);
        acc_next = acc_reg;
        if (ctl_reg.en) begin
            acc_next = (ctl_reg.clr ? '0 : acc_reg) + term;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

>>> sv/polar_angle_point_sort.sv
// Polar-angle point sorter, the ordering step of a Graham scan. Points
// (signed x, y) arrive one word at a time on s_; the word with s_is_last
// set closes the set and is part of it. The anchor is the lowest y, lowest
// x among ties (first loaded wins a full tie). It is emitted first on m_,
// then the other points by ascending angle about it, nearest first on equal
// angle, with m_final_point on the last word. Up to 64 points are held;
// further points are dropped and m_points_dropped is high on every word of
// that set. Load accepts one word per cycle. The sort is an insertion sort
// over a point memory with separate read and write ports, with every cross
// product and squared distance built on one shared 17x17 multiply-accumulate
// unit. Each point is set up (offset and squared distance) and then placed,
// after angle compares, plus a distance compare when the angles tie; the
// worst case has every compare a tie that moves the point. Each result word
// is held on m_ until taken before the next is read. s_ready is low from
// the last word of a set until its final result word is taken.
module polar_angle_point_sort
    import pas_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  coord_t s_point_x,
    input  coord_t s_point_y,
    input  logic   s_is_last,
    output logic   m_valid,
    input  logic   m_ready,
    output coord_t m_sorted_x,
    output coord_t m_sorted_y,
    output logic   m_final_point,
    output logic   m_points_dropped
);

    localparam logic [4:0] ST_LOAD   = 5'd0;
    localparam logic [4:0] ST_SW_RD  = 5'd1;
    localparam logic [4:0] ST_SW_WR1 = 5'd2;
    localparam logic [4:0] ST_SW_WR2 = 5'd3;
    localparam logic [4:0] ST_T_RD   = 5'd4;
    localparam logic [4:0] ST_T_LD   = 5'd5;
    localparam logic [4:0] ST_D1     = 5'd6;
    localparam logic [4:0] ST_D2     = 5'd7;
    localparam logic [4:0] ST_D3     = 5'd8;
    localparam logic [4:0] ST_D4     = 5'd9;
    localparam logic [4:0] ST_C_RD   = 5'd10;
    localparam logic [4:0] ST_C_LD   = 5'd11;
    localparam logic [4:0] ST_C_M1   = 5'd12;
    localparam logic [4:0] ST_C_M2   = 5'd13;
    localparam logic [4:0] ST_C_W    = 5'd14;
    localparam logic [4:0] ST_C_EV   = 5'd15;
    localparam logic [4:0] ST_E_M1   = 5'd16;
    localparam logic [4:0] ST_E_M2   = 5'd17;
    localparam logic [4:0] ST_E_W    = 5'd18;
    localparam logic [4:0] ST_E_EV   = 5'd19;
    localparam logic [4:0] ST_PLACE  = 5'd20;
    localparam logic [4:0] ST_O_RD   = 5'd21;
    localparam logic [4:0] ST_O_LD   = 5'd22;
    localparam logic [4:0] ST_O_WAIT = 5'd23;

    // point memory, {x, y} per entry, registered read
    logic [WORD_W-1:0] mem [MAX_POINTS];
    logic [WORD_W-1:0] rdata_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_addr;

    // control state
    logic [4:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] anc_idx_reg, anc_idx_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             m_valid_reg, m_valid_next;

    // datapath
    coord_t            anc_x_reg, anc_x_next;
    coord_t            anc_y_reg, anc_y_next;
    logic [WORD_W-1:0] t_reg, t_next;
    logic [WORD_W-1:0] e_reg, e_next;
    diff_t             tdx_reg, tdx_next;
    diff_t             tdy_reg, tdy_next;
    diff_t             edx_reg, edx_next;
    diff_t             edy_reg, edy_next;
    acc_t              td_reg, td_next;
    coord_t            out_x_reg, out_x_next;
    coord_t            out_y_reg, out_y_next;
    logic              out_fin_reg, out_fin_next;
    logic              out_drop_reg, out_drop_next;

    pas_mac_ctl_t mac_ctl;
    diff_t        mac_a;
    diff_t        mac_b;
    acc_t         mac_acc;

    logic take_point;
    logic cross_pos;
    logic cross_zero;

    pas_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .acc     (mac_acc)
    );

    assign s_ready    = (state_reg == ST_LOAD);
    assign cross_pos  = !mac_acc[ACC_W-1] && (mac_acc != '0);
    assign cross_zero = (mac_acc == '0);
    assign take_point = (count_reg == '0) || (s_point_y < anc_y_reg) ||
                        ((s_point_y == anc_y_reg) && (s_point_x < anc_x_reg));

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        anc_idx_next  = anc_idx_reg;
        ovf_next      = ovf_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        m_valid_next  = m_valid_reg;
        anc_x_next    = anc_x_reg;
        anc_y_next    = anc_y_reg;
        t_next        = t_reg;
        e_next        = e_reg;
        tdx_next      = tdx_reg;
        tdy_next      = tdy_reg;
        edx_next      = edx_reg;
        edy_next      = edy_reg;
        td_next       = td_reg;
        out_x_next    = out_x_reg;
        out_y_next    = out_y_reg;
        out_fin_next  = out_fin_reg;
        out_drop_next = out_drop_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;
        rd_addr       = '0;
        mac_ctl       = '0;
        mac_a         = '0;
        mac_b         = '0;

        case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    if (count_reg < CNT_W'(MAX_POINTS)) begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[IDX_W-1:0];
                        wr_data    = {s_point_x, s_point_y};
                        count_next = count_reg + CNT_W'(1);
                        if (take_point) begin
                            anc_idx_next = count_reg[IDX_W-1:0];
                            anc_x_next   = s_point_x;
                            anc_y_next   = s_point_y;
                        end
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_is_last) begin
                        state_next = ST_SW_RD;
                        i_next     = CNT_W'(2);
                        k_next     = '0;
                    end
                end
            end
            // move the anchor to slot 0
            ST_SW_RD: begin
                if (anc_idx_reg != '0) begin
                    state_next = ST_SW_WR1;
                end else begin
                    state_next = (count_reg > CNT_W'(2)) ? ST_T_RD : ST_O_RD;
                end
            end
            ST_SW_WR1: begin
                wr_en      = 1'b1;
                wr_addr    = anc_idx_reg;
                wr_data    = rdata_reg;
                state_next = ST_SW_WR2;
            end
            ST_SW_WR2: begin
                wr_en      = 1'b1;
                wr_data    = {anc_x_reg, anc_y_reg};
                state_next = (count_reg > CNT_W'(2)) ? ST_T_RD : ST_O_RD;
            end
            // fetch point i, its offset and squared distance
            ST_T_RD: begin
                rd_addr    = i_reg[IDX_W-1:0];
                state_next = ST_T_LD;
            end
            ST_T_LD: begin
                t_next     = rdata_reg;
                tdx_next   = coord_diff(rdata_reg[WORD_W-1:COORD_BITS], anc_x_reg);
                tdy_next   = coord_diff(rdata_reg[COORD_BITS-1:0], anc_y_reg);
                j_next     = i_reg[IDX_W-1:0];
                state_next = ST_D1;
            end
            ST_D1: begin
                mac_ctl    = '{en: 1'b1, clr: 1'b1, neg: 1'b0};
                mac_a      = tdx_reg;
                mac_b      = tdx_reg;
                state_next = ST_D2;
            end
            ST_D2: begin
                mac_ctl    = '{en: 1'b1, clr: 1'b0, neg: 1'b0};
                mac_a      = tdy_reg;
                mac_b      = tdy_reg;
                state_next = ST_D3;
            end
            ST_D3: begin
                state_next = ST_D4;
            end
            ST_D4: begin
                td_next    = mac_acc;
                state_next = ST_C_RD;
            end
            // compare against point j-1
            ST_C_RD: begin
                rd_addr    = j_reg - IDX_W'(1);
                state_next = ST_C_LD;
            end
            ST_C_LD: begin
                e_next     = rdata_reg;
                edx_next   = coord_diff(rdata_reg[WORD_W-1:COORD_BITS], anc_x_reg);
                edy_next   = coord_diff(rdata_reg[COORD_BITS-1:0], anc_y_reg);
                state_next = ST_C_M1;
            end
            ST_C_M1: begin
                mac_ctl    = '{en: 1'b1, clr: 1'b1, neg: 1'b0};
                mac_a      = tdx_reg;
                mac_b      = edy_reg;
                state_next = ST_C_M2;
            end
            ST_C_M2: begin
                mac_ctl    = '{en: 1'b1, clr: 1'b0, neg: 1'b1};
                mac_a      = tdy_reg;
                mac_b      = edx_reg;
                state_next = ST_C_W;
            end
            ST_C_W: begin
                state_next = ST_C_EV;
            end
            ST_C_EV: begin
                if (cross_pos) begin
                    wr_en      = 1'b1;
                    wr_addr    = j_reg;
                    wr_data    = e_reg;
                    j_next     = j_reg - IDX_W'(1);
                    state_next = (j_reg > IDX_W'(2)) ? ST_C_RD : ST_PLACE;
                end else if (cross_zero) begin
                    state_next = ST_E_M1;
                end else begin
                    state_next = ST_PLACE;
                end
            end
            // collinear: farther point moves up
            ST_E_M1: begin
                mac_ctl    = '{en: 1'b1, clr: 1'b1, neg: 1'b0};
                mac_a      = edx_reg;
                mac_b      = edx_reg;
                state_next = ST_E_M2;
            end
            ST_E_M2: begin
                mac_ctl    = '{en: 1'b1, clr: 1'b0, neg: 1'b0};
                mac_a      = edy_reg;
                mac_b      = edy_reg;
                state_next = ST_E_W;
            end
            ST_E_W: begin
                state_next = ST_E_EV;
            end
            ST_E_EV: begin
                if (mac_acc > td_reg) begin
                    wr_en      = 1'b1;
                    wr_addr    = j_reg;
                    wr_data    = e_reg;
                    j_next     = j_reg - IDX_W'(1);
                    state_next = (j_reg > IDX_W'(2)) ? ST_C_RD : ST_PLACE;
                end else begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                wr_en      = 1'b1;
                wr_addr    = j_reg;
                wr_data    = t_reg;
                i_next     = i_reg + CNT_W'(1);
                state_next = ((i_reg + CNT_W'(1)) < count_reg) ? ST_T_RD : ST_O_RD;
            end
            // emission
            ST_O_RD: begin
                rd_addr    = k_reg;
                state_next = ST_O_LD;
            end
            ST_O_LD: begin
                out_x_next    = rdata_reg[WORD_W-1:COORD_BITS];
                out_y_next    = rdata_reg[COORD_BITS-1:0];
                out_fin_next  = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);
                out_drop_next = ovf_reg;
                m_valid_next  = 1'b1;
                state_next    = ST_O_WAIT;
            end
            ST_O_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (out_fin_reg) begin
                        count_next   = '0;
                        anc_idx_next = '0;
                        ovf_next     = 1'b0;
                        state_next   = ST_LOAD;
                    end else begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = ST_O_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            anc_idx_reg <= '0;
            ovf_reg     <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            anc_idx_reg <= anc_idx_next;
            ovf_reg     <= ovf_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        anc_x_reg    <= anc_x_next;
        anc_y_reg    <= anc_y_next;
        t_reg        <= t_next;
        e_reg        <= e_next;
        tdx_reg      <= tdx_next;
        tdy_reg      <= tdy_next;
        edx_reg      <= edx_next;
        edy_reg      <= edy_next;
        td_reg       <= td_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_fin_reg  <= out_fin_next;
        out_drop_reg <= out_drop_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign m_valid          = m_valid_reg;
    assign m_sorted_x       = out_x_reg;
    assign m_sorted_y       = out_y_reg;
    assign m_final_point    = out_fin_reg;
    assign m_points_dropped = out_drop_reg;

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result word is pending");

    // final word taken returns the block to loading, set state cleared
    a_final_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_final_point) |=>
            (s_ready && count_reg == '0 && !ovf_reg))
        else $error("set state not cleared after final word");

    // a word that is not last keeps the block loading
    a_keep_loading: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_is_last) |=> s_ready)
        else $error("left loading on a word that is not last");

    // held count never exceeds capacity
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (count_reg <= CNT_W'(MAX_POINTS)))
        else $error("point count beyond capacity");

endmodule

>>> bench/angular_order_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the sorter, keeps its own copy of the point set,
// predicts the emitted order and compares every result word against it.
module angular_order_checker
    import pas_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    input  logic   s_ready,
    input  coord_t s_point_x,
    input  coord_t s_point_y,
    input  logic   s_is_last,
    input  logic   m_valid,
    input  logic   m_ready,
    input  coord_t m_sorted_x,
    input  coord_t m_sorted_y,
    input  logic   m_final_point,
    input  logic   m_points_dropped,
    output int     fail_count,
    output int     words_waiting,
    output int     words_checked
);

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
        logic   dropped;
    } sorted_word_t;

    coord_t       hold_x [MAX_POINTS];
    coord_t       hold_y [MAX_POINTS];
    int           held_count;
    int           low_slot;
    logic         spilled;
    sorted_word_t expected_words [$];

    function automatic longint reach_sq(input coord_t ax, input coord_t ay,
                                        input coord_t bx, input coord_t by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return dx * dx + dy * dy;
    endfunction

    // anchor first, then insertion sort by cross-product sign, nearest first on ties
    task automatic queue_angular_order();
        coord_t       ox [MAX_POINTS];
        coord_t       oy [MAX_POINTS];
        coord_t       tx;
        coord_t       ty;
        longint       x0;
        longint       y0;
        longint       td;
        longint       turn;
        int           i;
        int           j;
        logic         moving;
        sorted_word_t w;
        for (i = 0; i < held_count; i++) begin
            ox[i] = hold_x[i];
            oy[i] = hold_y[i];
        end
        if (low_slot != 0) begin
            tx = ox[0];
            ty = oy[0];
            ox[0] = ox[low_slot];
            oy[0] = oy[low_slot];
            ox[low_slot] = tx;
            oy[low_slot] = ty;
        end
        x0 = longint'(ox[0]);
        y0 = longint'(oy[0]);
        for (i = 2; i < held_count; i++) begin
            tx = ox[i];
            ty = oy[i];
            td = reach_sq(tx, ty, ox[0], oy[0]);
            j = i;
            moving = 1'b1;
            while (moving && j > 1) begin
                turn = (longint'(tx) - x0) * (longint'(oy[j-1]) - y0)
                     - (longint'(ty) - y0) * (longint'(ox[j-1]) - x0);
                if (turn > 0 || (turn == 0 && reach_sq(ox[j-1], oy[j-1], ox[0], oy[0]) > td)) begin
                    ox[j] = ox[j-1];
                    oy[j] = oy[j-1];
                    j--;
                end else begin
                    moving = 1'b0;
                end
            end
            ox[j] = tx;
            oy[j] = ty;
        end
        for (i = 0; i < held_count; i++) begin
            w.x       = ox[i];
            w.y       = oy[i];
            w.last    = (i == held_count - 1);
            w.dropped = spilled;
            expected_words.push_back(w);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        sorted_word_t want;
        if (!aresetn) begin
            held_count    = 0;
            low_slot      = 0;
            spilled       = 1'b0;
            fail_count    = 0;
            words_checked = 0;
            expected_words.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (held_count < MAX_POINTS) begin
                    hold_x[held_count] = s_point_x;
                    hold_y[held_count] = s_point_y;
                    if (held_count == 0 || s_point_y < hold_y[low_slot] ||
                        (s_point_y == hold_y[low_slot] && s_point_x < hold_x[low_slot]))
                        low_slot = held_count;
                    held_count++;
                end else begin
                    spilled = 1'b1;
                end
                if (s_is_last) begin
                    queue_angular_order();
                    held_count = 0;
                    low_slot   = 0;
                    spilled    = 1'b0;
                end
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got x=%0d y=%0d last=%0b drop=%0b",
                             $realtime, m_sorted_x, m_sorted_y, m_final_point, m_points_dropped);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("sorted_x", want.x, m_sorted_x);
                    check_field("sorted_y", want.y, m_sorted_y);
                    check_field("final_point", want.last, m_final_point);
                    check_field("points_dropped", want.dropped, m_points_dropped);
                    words_checked++;
                end
            end
        end
        words_waiting = expected_words.size();
    end

endmodule

>>> bench/polar_angle_point_sort_test.sv
`timescale 1ns / 1ps

// Top of the sorter bench: drives point words, throttles the result side,
// and gives the verdict. Prediction and comparison live in the checker.
module polar_angle_point_sort_test;
    import pas_pkg::*;

    // ~320 words in all; the run ends well before the cycle limit even with
    // three full-size sets and heavy stalling.
    localparam int ITEM_TARGET = 320;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int IDLE_PCT    = 32;

    logic   aclk    = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    coord_t s_point_x = '0;
    coord_t s_point_y = '0;
    logic   s_is_last = 1'b0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    coord_t m_sorted_x;
    coord_t m_sorted_y;
    logic   m_final_point;
    logic   m_points_dropped;

    int   fail_count;
    int   words_waiting;
    int   words_checked;
    int   cycle_count = 0;
    int   items_sent  = 0;
    int   sets_sent   = 0;
    int   spilled_sets = 0;
    logic steady = 1'b0;   // no idling on either side while set

    polar_angle_point_sort dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_point_x        (s_point_x),
        .s_point_y        (s_point_y),
        .s_is_last        (s_is_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sorted_x       (m_sorted_x),
        .m_sorted_y       (m_sorted_y),
        .m_final_point    (m_final_point),
        .m_points_dropped (m_points_dropped)
    );

    angular_order_checker order_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_point_x        (s_point_x),
        .s_point_y        (s_point_y),
        .s_is_last        (s_is_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sorted_x       (m_sorted_x),
        .m_sorted_y       (m_sorted_y),
        .m_final_point    (m_final_point),
        .m_points_dropped (m_points_dropped),
        .fail_count       (fail_count),
        .words_waiting    (words_waiting),
        .words_checked    (words_checked)
    );

    always #5 aclk = ~aclk;

    // watchdog: a hung handshake or a lost result word ends here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side back-pressure, changed on the falling edge only
    always @(negedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // One point word. Called at a falling edge; returns at the falling edge
    // after acceptance. Valid is dropped only for a random gap, so it never
    // gets two writes in one step.
    task automatic send_point(input int x, input int y, input logic last);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_point_x <= coord_t'(x);
        s_point_y <= coord_t'(y);
        s_is_last <= last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (last)
            sets_sent++;
        @(negedge aclk);
    endtask

    // coordinate flavors: full range, tight grid (collinear and duplicate
    // points galore), and the edges of the 16-bit range
    function automatic int pick_coord(input int mode);
        case (mode)
            0: return int'($urandom_range(65535)) - 32768;
            1: return int'($urandom_range(6)) - 3;
            default: begin
                case ($urandom_range(7))
                    0: return -32768;
                    1: return -32767;
                    2: return -1;
                    3: return 0;
                    4: return 1;
                    5: return 32766;
                    6: return 32767;
                    default: return int'($urandom_range(65535)) - 32768;
                endcase
            end
        endcase
    endfunction

    initial begin
        int set_no;
        int set_size;
        int mode;
        int k;

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // single-point set at the most negative corner
        send_point(-32768, -32768, 1'b1);

        // corners of the range: differences up to 65535, anchor at lowest y
        send_point(32767, 32767, 1'b0);
        send_point(-32768, 32767, 1'b0);
        send_point(32767, -32768, 1'b0);
        send_point(-32768, -32767, 1'b0);
        send_point(0, 0, 1'b1);

        // y tie broken by x, copies of the anchor, collinear runs at
        // different distances, a late point that takes over the anchor
        send_point(5, 0, 1'b0);
        send_point(-3, 0, 1'b0);
        send_point(7, 4, 1'b0);
        send_point(2, 2, 1'b0);
        send_point(-3, 0, 1'b0);
        send_point(-3, 5, 1'b0);
        send_point(10, 0, 1'b0);
        send_point(-8, 0, 1'b1);

        // two points, anchor arrives second
        send_point(0, 0, 1'b0);
        send_point(0, -1, 1'b1);

        // all points identical
        send_point(7, 7, 1'b0);
        send_point(7, 7, 1'b0);
        send_point(7, 7, 1'b1);

        // hold off until every sorted word has drained
        s_valid <= 1'b0;
        while (words_waiting != 0)
            @(negedge aclk);

        // Random sets, mostly small. Three sets hit capacity: exactly full,
        // one over (the last word is dropped), and three over.
        set_no = 0;
        while (items_sent < ITEM_TARGET) begin
            steady = (items_sent >= 150 && items_sent < 220);
            case (set_no)
                4:  set_size = MAX_POINTS;
                12: set_size = MAX_POINTS + 1;
                20: set_size = MAX_POINTS + 3;
                default: begin
                    if ($urandom_range(99) < 85)
                        set_size = $urandom_range(9, 1);
                    else
                        set_size = $urandom_range(24, 10);
                end
            endcase
            if (set_size > MAX_POINTS)
                spilled_sets++;
            mode = $urandom_range(2);
            for (k = 0; k < set_size; k++)
                send_point(pick_coord(mode), pick_coord(mode), k == set_size - 1);
            set_no++;
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        // drain, then give a stray word time to show up
        while (words_waiting != 0)
            @(negedge aclk);
        repeat (40) @(negedge aclk);

        $display("Sent %0d points in %0d sets (%0d over capacity); checked %0d sorted words.",
                 items_sent, sets_sent, spilled_sets, words_checked);
        if (fail_count == 0 && words_waiting == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
sv/pas_pkg.sv
sv/pas_mac.sv
sv/polar_angle_point_sort.sv
bench/angular_order_checker.sv
bench/polar_angle_point_sort_test.sv
